### rtl/ceguid_pkg.sv
// Shared types, codes and helper functions for the compact extended GUID decoder.
// No dependencies; used by every module under rtl/.
package ceguid_pkg;

   // width codes carried with each result
   localparam logic [2:0] WC_NULL = 3'd0;
   localparam logic [2:0] WC_N5   = 3'd1;
   localparam logic [2:0] WC_N10  = 3'd2;
   localparam logic [2:0] WC_N17  = 3'd3;
   localparam logic [2:0] WC_FULL = 3'd4;
   localparam logic [2:0] WC_AUTO = 3'd5;
   localparam logic [2:0] WC_BAD  = 3'd7;

   localparam logic [4:0] GUID_BYTES = 5'd16;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam int RSP_DATA_W = 160;
   localparam int RSP_USER_W = 4;

   typedef enum logic [2:0] {
      PH_HEADER = 3'b001,
      PH_NFIELD = 3'b010,
      PH_GUID   = 3'b100
   } phase_type;

   typedef struct packed {
      logic [31:0] n_value;
      logic [63:0] guid_high;
      logic [63:0] guid_low;
      logic [2:0]  width_code;
      logic        format_error;
   } result_type;

   function automatic logic [2:0] form_of(input logic [7:0] h);
      logic [2:0] code;
      begin
         if (h == 8'd0)                     code = WC_NULL;
         else if (h[2:0] == 3'd4)           code = WC_N5;
         else if (h[5:0] == 6'd32)          code = WC_N10;
         else if (h[6:0] == 7'd64)          code = WC_N17;
         else if (h == 8'd128)              code = WC_FULL;
         else                               code = WC_BAD;
         return code;
      end
   endfunction

   function automatic logic [4:0] nfield_len(input logic [2:0] code);
      logic [4:0] len;
      begin
         case (code)
            WC_N10:  len = 5'd1;
            WC_N17:  len = 5'd2;
            WC_FULL: len = 5'd4;
            default: len = 5'd0;
         endcase
         return len;
      end
   endfunction

endpackage

### rtl/ceguid_front.sv
// Front end: parses the byte stream, assembles n and the GUID, pushes finished results.
// Depends on ceguid_pkg.
module ceguid_front (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   little_endian,
   input  logic                   byte_valid,
   input  logic [7:0]             byte_data,
   output logic                   push,
   output ceguid_pkg::result_type push_data
);

   ceguid_pkg::phase_type phase_ff, phase_in;
   logic [4:0]  left_ff, left_in;
   logic [7:0]  header_ff, header_in;
   logic [31:0] n_ff, n_in;
   logic [63:0] hi_ff, hi_in;
   logic [63:0] lo_ff, lo_in;
   logic [2:0]  last_ff, last_in;

   logic [2:0]  hdr_code;
   logic [4:0]  len;
   logic [1:0]  nidx;
   logic [3:0]  k;
   logic [5:0]  pos;
   logic [4:0]  left_dec;
   logic [31:0] n_done;

   always_comb begin
      hdr_code = ceguid_pkg::form_of(byte_data);
      len      = ceguid_pkg::nfield_len(ceguid_pkg::form_of(header_ff));
      nidx     = 2'(len - left_ff);
      k        = 4'(ceguid_pkg::GUID_BYTES - left_ff);
      left_dec = (left_ff != 5'd0) ? left_ff - 5'd1 : 5'd0;

      // GUID byte lane: data1/2/3 follow the byte order, data4 shifts in
      if (k < 4'd4)
         pos = little_endian ? 6'(6'd32 + {k[1:0], 3'b000})
                             : 6'(6'd32 + {2'(2'd3 - k[1:0]), 3'b000});
      else if (k < 4'd6)
         pos = 6'(6'd16 + {(little_endian ? k[0] : ~k[0]), 3'b000});
      else
         pos = {2'b00, (little_endian ? k[0] : ~k[0]), 3'b000};

      case (ceguid_pkg::form_of(header_ff))
         ceguid_pkg::WC_N5:  n_done = {27'd0, header_ff[7:3]};
         ceguid_pkg::WC_N10: n_done = {22'd0, n_ff[7:0], header_ff[7:6]};
         ceguid_pkg::WC_N17: n_done = {15'd0, n_ff[15:0], header_ff[7]};
         default:            n_done = n_ff;
      endcase

      phase_in  = phase_ff;
      left_in   = left_ff;
      header_in = header_ff;
      n_in      = n_ff;
      hi_in     = hi_ff;
      lo_in     = lo_ff;
      last_in   = last_ff;
      push      = 1'b0;
      push_data = '0;

      if (byte_valid) begin
         case (phase_ff)
            ceguid_pkg::PH_NFIELD: begin
               if (little_endian)
                  n_in = n_ff | ({24'd0, byte_data} << {nidx, 3'b000});
               else
                  n_in = {n_ff[23:0], byte_data};
               left_in = left_dec;
               if (left_dec == 5'd0) begin
                  phase_in = ceguid_pkg::PH_GUID;
                  left_in  = ceguid_pkg::GUID_BYTES;
               end
            end
            ceguid_pkg::PH_GUID: begin
               if (k < 4'd8)
                  hi_in = hi_ff | ({56'd0, byte_data} << pos);
               else
                  lo_in = {lo_ff[55:0], byte_data};
               left_in = left_dec;
               if (left_dec == 5'd0) begin
                  phase_in               = ceguid_pkg::PH_HEADER;
                  push                   = 1'b1;
                  push_data.n_value      = n_done;
                  push_data.guid_high    = hi_in;
                  push_data.guid_low     = lo_in;
                  push_data.width_code   = last_ff;
               end
            end
            default: begin
               phase_in = ceguid_pkg::PH_HEADER;
               left_in  = 5'd0;
               if (hdr_code == ceguid_pkg::WC_BAD) begin
                  push                   = 1'b1;
                  push_data.width_code   = last_ff;
                  push_data.format_error = 1'b1;
               end else begin
                  header_in = byte_data;
                  last_in   = hdr_code;
                  n_in      = '0;
                  hi_in     = '0;
                  lo_in     = '0;
                  if (hdr_code == ceguid_pkg::WC_NULL) begin
                     push = 1'b1;
                  end else if (hdr_code == ceguid_pkg::WC_N5) begin
                     phase_in = ceguid_pkg::PH_GUID;
                     left_in  = ceguid_pkg::GUID_BYTES;
                  end else begin
                     phase_in = ceguid_pkg::PH_NFIELD;
                     left_in  = ceguid_pkg::nfield_len(hdr_code);
                  end
               end
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff  <= ceguid_pkg::PH_HEADER;
         left_ff   <= '0;
         header_ff <= '0;
         n_ff      <= '0;
         hi_ff     <= '0;
         lo_ff     <= '0;
         last_ff   <= ceguid_pkg::WC_AUTO;
      end else begin
         phase_ff  <= phase_in;
         left_ff   <= left_in;
         header_ff <= header_in;
         n_ff      <= n_in;
         hi_ff     <= hi_in;
         lo_ff     <= lo_in;
         last_ff   <= last_in;
      end
   end

endmodule

### rtl/ceguid_queue.sv
// Short result queue between the parser and the output stage.
// Depends on ceguid_pkg.
module ceguid_queue (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   push,
   input  ceguid_pkg::result_type push_data,
   input  logic                   pop,
   output logic                   not_empty,
   output logic                   full,
   output ceguid_pkg::result_type head
);

   ceguid_pkg::result_type entry_ff [ceguid_pkg::QUEUE_DEPTH];
   logic [ceguid_pkg::QPTR_W-1:0] wr_ptr_ff, wr_ptr_in;
   logic [ceguid_pkg::QPTR_W-1:0] rd_ptr_ff, rd_ptr_in;
   logic [ceguid_pkg::QCNT_W-1:0] count_ff, count_in;

   localparam logic [ceguid_pkg::QPTR_W-1:0] LAST_PTR =
      ceguid_pkg::QPTR_W'(ceguid_pkg::QUEUE_DEPTH - 1);

   assign not_empty = (count_ff != '0);
   assign full      = (count_ff == ceguid_pkg::QCNT_W'(ceguid_pkg::QUEUE_DEPTH));
   assign head      = entry_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push)
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + 1'b1;
      if (pop)
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + 1'b1;
      if (push && !pop)
         count_in = count_ff + 1'b1;
      else if (pop && !push)
         count_in = count_ff - 1'b1;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push)
         entry_ff[wr_ptr_ff] <= push_data;
   end

endmodule

### rtl/ceguid_back.sv
// Output stage: pulls results from the queue into the response register.
// Depends on ceguid_pkg.
module ceguid_back (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   q_not_empty,
   input  ceguid_pkg::result_type q_head,
   output logic                   q_pop,
   output logic                   out_valid,
   input  logic                   out_ready,
   output ceguid_pkg::result_type out_data
);

   logic                   valid_ff, valid_in;
   ceguid_pkg::result_type data_ff;

   // reload whenever the register is empty or its word is taken this cycle
   assign q_pop     = q_not_empty && (!valid_ff || out_ready);
   assign out_valid = valid_ff;
   assign out_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (q_pop)
         valid_in = 1'b1;
      else if (out_ready)
         valid_in = 1'b0;
   end

   always_ff @(posedge clock) begin
      if (reset)
         valid_ff <= 1'b0;
      else
         valid_ff <= valid_in;
   end

   always_ff @(posedge clock) begin
      if (q_pop)
         data_ff <= q_head;
   end

endmodule

### rtl/compact_ext_guid_decoder.sv
// Compact extended GUID decoder: takes one byte per cycle and emits one word per decoded
// GUID (or per null or bad header). For each accepted byte the parser advances a
// phase/byte counter and shift registers, so a sustained rate of one byte per
// clock holds while the response side keeps up. A 2-word queue and an output register sit
// between parser and response port, so req_tready only drops once both are full. The
// csr register selects byte order (1 little-endian, reset value) and is read per byte.
module compact_ext_guid_decoder (
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_wr_en,
   input  logic         csr_wr_data,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [7:0]   req_tdata,   // [7:0] in_byte
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [159:0] rsp_tdata,   // [31:0] n_value, [95:32] guid_high, [159:96] guid_low
   output logic [3:0]   rsp_tuser    // [2:0] width_code, [3] format_error
);

   logic                   little_endian_ff;
   logic                   push, pop, q_not_empty, q_full;
   ceguid_pkg::result_type push_data, q_head, out_data;

   assign req_tready = !q_full;

   always_ff @(posedge clock) begin
      if (reset)
         little_endian_ff <= 1'b1;
      else if (csr_wr_en)
         little_endian_ff <= csr_wr_data;
   end

   ceguid_front u_front (
      .clock        (clock),
      .reset        (reset),
      .little_endian(little_endian_ff),
      .byte_valid   (req_tvalid && req_tready),
      .byte_data    (req_tdata),
      .push         (push),
      .push_data    (push_data)
   );

   ceguid_queue u_queue (
      .clock    (clock),
      .reset    (reset),
      .push     (push),
      .push_data(push_data),
      .pop      (pop),
      .not_empty(q_not_empty),
      .full     (q_full),
      .head     (q_head)
   );

   ceguid_back u_back (
      .clock      (clock),
      .reset      (reset),
      .q_not_empty(q_not_empty),
      .q_head     (q_head),
      .q_pop      (pop),
      .out_valid  (rsp_tvalid),
      .out_ready  (rsp_tready),
      .out_data   (out_data)
   );

   assign rsp_tdata = {out_data.guid_low, out_data.guid_high, out_data.n_value};
   assign rsp_tuser = {out_data.format_error, out_data.width_code};

endmodule
